[rtl/core/joystick_calibrate_and_map_top_macros.svh]
// Assertion macros shared by the joystick calibration RTL
`ifndef JOYSTICK_CALIBRATE_AND_MAP_TOP_MACROS_SVH
`define JOYSTICK_CALIBRATE_AND_MAP_TOP_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define JCM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset
`define JCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/core/jcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcm_pkg
// Types and constants shared by the joystick calibration and mapping block.
// ----------------------------------------------------------------------------
package jcm_pkg;
   localparam int SmpW   = 12;
   localparam int NumAxes = 4;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_ABORT  = 2'd2;
   localparam logic [1:0] CMD_RESET  = 2'd3;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_LMIN = 3'd1;
   localparam logic [2:0] PH_RCTR = 3'd6;
   localparam logic [2:0] PH_DONE = 3'd7;

   localparam logic [2:0] REG_STABLE  = 3'd0;
   localparam logic [2:0] REG_CLOW    = 3'd1;
   localparam logic [2:0] REG_CHIGH   = 3'd2;
   localparam logic [2:0] REG_MLOW    = 3'd3;
   localparam logic [2:0] REG_MHIGH   = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [11:0] left_x_raw;
      logic [11:0] left_y_raw;
      logic [11:0] right_x_raw;
      logic [11:0] right_y_raw;
   } req_type;

   typedef struct packed {
      logic [7:0] left_x_out;
      logic [7:0] left_y_out;
      logic [7:0] right_x_out;
      logic [7:0] right_y_out;
      logic [2:0] phase;
      logic       calibrating;
      logic       complete;
   } rsp_type;

   // Work item passed from front to back: samples plus calibration snapshot
   typedef struct packed {
      logic                          is_sample;
      logic [2:0]                    phase;
      logic [NumAxes-1:0][SmpW-1:0]  smp;
      logic [NumAxes-1:0][SmpW-1:0]  lo;
      logic [NumAxes-1:0][SmpW-1:0]  hi;
      logic [NumAxes-1:0][SmpW-1:0]  mid;
   } work_type;
endpackage

[rtl/core/jcm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcm_front
// Accepts requests, runs the calibration sequencer and snapshots the
// calibration data into a work item for the mapping back end.
// ----------------------------------------------------------------------------
module jcm_front
   import jcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   input  logic        q_full,
   output logic        q_push,
   output work_type    q_data,
   input  logic [15:0] stable_samples,
   input  logic [11:0] corner_low_limit,
   input  logic [11:0] corner_high_limit,
   input  logic [11:0] center_low_limit,
   input  logic [11:0] center_high_limit
);
   logic [NumAxes-1:0][SmpW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [SmpW-1:0] a, b;
   logic [1:0]  kind;
   logic        right, ok, fire;
   logic [15:0] cnt_inc;

   assign fire = req_push && !q_full;
   assign q_push = fire;

   // Select the pair under test and classify it
   always_comb begin
      right = (phase_ff > 3'd3);
      a = right ? req_data.right_x_raw : req_data.left_x_raw;
      b = right ? req_data.right_y_raw : req_data.left_y_raw;
      unique case (phase_ff)
         3'd1, 3'd4: kind = 2'd0;
         3'd2, 3'd5: kind = 2'd1;
         default:    kind = 2'd2;
      endcase
      unique case (kind)
         2'd0:    ok = (a < corner_low_limit) && (b < corner_low_limit);
         2'd1:    ok = (a > corner_high_limit) && (b > corner_high_limit);
         default: ok = (a > center_low_limit) && (a < center_high_limit) &&
                       (b > center_low_limit) && (b < center_high_limit);
      endcase
      cnt_inc = cnt_ff + 16'd1;
   end

   // Advance the sequencer
   always_comb begin
      lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff;
      phase_in = phase_ff; cnt_in = cnt_ff;
      if (fire) begin
         unique case (req_data.cmd)
            CMD_SAMPLE: begin
               if (phase_ff >= PH_LMIN && phase_ff <= PH_RCTR) begin
                  if (!ok) begin
                     cnt_in = '0;
                  end else if (cnt_inc >= stable_samples) begin
                     cnt_in = '0;
                     phase_in = phase_ff + 3'd1;
                     unique case (kind)
                        2'd0: begin
                           lo_in[{right, 1'b0}] = a; lo_in[{right, 1'b1}] = b;
                        end
                        2'd1: begin
                           hi_in[{right, 1'b0}] = a; hi_in[{right, 1'b1}] = b;
                        end
                        default: begin
                           mid_in[{right, 1'b0}] = a; mid_in[{right, 1'b1}] = b;
                        end
                     endcase
                  end else begin
                     cnt_in = cnt_inc;
                  end
               end
            end
            CMD_START: begin
               phase_in = PH_LMIN; cnt_in = '0;
            end
            CMD_ABORT: begin
               phase_in = PH_IDLE; cnt_in = '0;
            end
            default: begin
               phase_in = PH_IDLE; cnt_in = '0;
               for (int i = 0; i < NumAxes; i++) begin
                  lo_in[i] = '0; hi_in[i] = '1; mid_in[i] = {1'b1, {(SmpW-1){1'b0}}};
               end
            end
         endcase
      end
   end

   // Build the work item from the post-step state
   always_comb begin
      q_data.is_sample = (req_data.cmd == CMD_SAMPLE);
      q_data.phase = phase_in;
      q_data.smp[0] = req_data.left_x_raw;
      q_data.smp[1] = req_data.left_y_raw;
      q_data.smp[2] = req_data.right_x_raw;
      q_data.smp[3] = req_data.right_y_raw;
      q_data.lo = lo_in; q_data.hi = hi_in; q_data.mid = mid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff <= '0;
         for (int i = 0; i < NumAxes; i++) begin
            lo_ff[i] <= '0; hi_ff[i] <= '1; mid_ff[i] <= {1'b1, {(SmpW-1){1'b0}}};
         end
      end else begin
         phase_ff <= phase_in; cnt_ff <= cnt_in;
         lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in;
      end
   end

`include "joystick_calibrate_and_map_top_macros.svh"
   `JCM_ASSERT_NEXT(a_hold_idle, clock, reset, !fire, phase_ff == $past(phase_ff))
   `JCM_ASSERT_NEXT(a_start, clock, reset, fire && req_data.cmd == CMD_START, phase_ff == PH_LMIN)
   `JCM_ASSERT_IMPL(a_cnt_zero_idle, clock, reset, phase_ff == PH_IDLE || phase_ff == PH_DONE, cnt_ff == 16'd0 || $past(phase_ff) == phase_ff)
endmodule

[rtl/core/jcm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcm_queue
// Two-entry queue of work items between the front and back ends.
// ----------------------------------------------------------------------------
module jcm_queue
   import jcm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type wdata,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output work_type rdata
);
   work_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign rdata = mem_ff[rp_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wdata;
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

`include "joystick_calibrate_and_map_top_macros.svh"
   `JCM_ASSERT_IMPL(a_no_overflow, clock, reset, full, !push)
   `JCM_ASSERT_IMPL(a_no_underflow, clock, reset, empty, !pop)
   `JCM_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff != 2'd3)
endmodule

[rtl/core/jcm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcm_back
// Maps the four axes of a sample work item with one shared restoring divider,
// one axis after another, and holds the finished result for the consumer.
// ----------------------------------------------------------------------------
module jcm_back
   import jcm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  work_type q_data,
   output logic     q_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SETUP = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;
   localparam int NumW = SmpW + 7;

   logic [1:0]  st_ff, st_in;
   logic [1:0]  ax_ff, ax_in;
   logic [4:0]  bit_ff, bit_in;
   logic [NumW-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [SmpW:0]   rem_ff, rem_in;
   logic [SmpW-1:0] den_ff, den_in;
   logic            up_ff, up_in;
   logic [3:0][7:0] res_ff, res_in;
   logic            full_ff, full_in;
   rsp_type         out_ff, out_in;
   logic [SmpW-1:0] v, lo, hi, c;
   logic [SmpW:0]   trial;
   logic [7:0]      done_val;

   assign v  = q_data.smp[ax_ff];
   assign lo = q_data.lo[ax_ff];
   assign hi = q_data.hi[ax_ff];
   assign c  = q_data.mid[ax_ff];
   assign trial = {rem_ff[SmpW-1:0], num_ff[NumW-1]};
   assign done_val = up_ff ? 8'd128 + quo_ff[7:0] : 8'd128 - quo_ff[7:0];
   assign rsp_empty = !full_ff;
   assign rsp_data = out_ff;

   always_comb begin
      st_in = st_ff; ax_in = ax_ff; bit_in = bit_ff; num_in = num_ff;
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff; up_in = up_ff;
      res_in = res_ff; full_in = full_ff && !rsp_pop; out_in = out_ff;
      q_pop = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               ax_in = '0;
               st_in = q_data.is_sample ? ST_SETUP : ST_OUT;
               res_in = '0;
            end
         end
         // Pick the segment; settle clamped cases directly
         ST_SETUP: begin
            rem_in = '0; quo_in = '0; bit_in = 5'(NumW);
            if (v <= c) begin
               up_in = 1'b0; den_in = c - lo;
               num_in = NumW'({7'd0, c - v} << 7);
               if (v <= lo) begin
                  res_in[ax_ff] = 8'd0; st_in = ST_SETUP; ax_in = ax_ff + 2'd1;
                  if (ax_ff == 2'd3) st_in = ST_OUT;
               end else begin
                  st_in = ST_DIV;
               end
            end else begin
               up_in = 1'b1; den_in = hi - c;
               num_in = NumW'(({7'd0, v - c} << 7) - {7'd0, v - c});
               if (v >= hi) begin
                  res_in[ax_ff] = 8'd255; ax_in = ax_ff + 2'd1;
                  if (ax_ff == 2'd3) st_in = ST_OUT;
               end else begin
                  st_in = ST_DIV;
               end
            end
         end
         // One quotient bit per cycle
         ST_DIV: begin
            if (bit_ff == 5'd0) begin
               res_in[ax_ff] = done_val; ax_in = ax_ff + 2'd1;
               st_in = (ax_ff == 2'd3) ? ST_OUT : ST_SETUP;
            end else begin
               num_in = num_ff << 1;
               if (trial >= {1'b0, den_ff}) begin
                  rem_in = trial - {1'b0, den_ff};
                  quo_in = {quo_ff[NumW-2:0], 1'b1};
               end else begin
                  rem_in = trial;
                  quo_in = {quo_ff[NumW-2:0], 1'b0};
               end
               bit_in = bit_ff - 5'd1;
            end
         end
         default: begin
            if (!full_ff || rsp_pop) begin
               q_pop = 1'b1; full_in = 1'b1; st_in = ST_IDLE;
               out_in.left_x_out = res_ff[0]; out_in.left_y_out = res_ff[1];
               out_in.right_x_out = res_ff[2]; out_in.right_y_out = res_ff[3];
               out_in.phase = q_data.phase;
               out_in.calibrating = (q_data.phase >= PH_LMIN) && (q_data.phase <= PH_RCTR);
               out_in.complete = (q_data.phase == PH_DONE);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; full_ff <= 1'b0;
      end else begin
         st_ff <= st_in; full_ff <= full_in;
      end
      ax_ff <= ax_in; bit_ff <= bit_in; num_ff <= num_in; quo_ff <= quo_in;
      rem_ff <= rem_in; den_ff <= den_in; up_ff <= up_in; res_ff <= res_in;
      out_ff <= out_in;
   end

`include "joystick_calibrate_and_map_top_macros.svh"
   `JCM_ASSERT_IMPL(a_pop_out, clock, reset, q_pop, st_ff == ST_OUT && !q_empty)
   `JCM_ASSERT_NEXT(a_res_valid, clock, reset, q_pop, !rsp_empty)
   `JCM_ASSERT_IMPL(a_div_den, clock, reset, st_ff == ST_DIV, den_ff != '0)
endmodule

[rtl/core/joystick_calibrate_and_map_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_calibrate_and_map_top
// Joystick three-point calibration with piecewise-linear axis mapping.
//
//   channel | ports              | handshake
//   request | req_push/req_full  | push && !full
//   result  | rsp_pop/rsp_empty  | pop && !empty
//   config  | csr_psel..pready   | psel && penable && pwrite
//
// Samples are mapped by the single shared divider, which computes one quotient
// bit per cycle, one axis after another.
// The front end runs calibration in the cycle of acceptance; a two-entry
// queue lets it take requests while the back end maps. Synchronous reset
// restores defaults and calibration data. A stalled result holds the back end.
// ----------------------------------------------------------------------------
module joystick_calibrate_and_map_top
   import jcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [15:0] stable_ff;
   logic [11:0] clow_ff, chigh_ff, mlow_ff, mhigh_ff;
   logic        q_push, q_full, q_pop, q_empty, wr;
   work_type    q_wdata, q_rdata;
   logic [2:0]  idx;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[4:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 16'd50; clow_ff <= 12'd500; chigh_ff <= 12'd3595;
         mlow_ff <= 12'd1848; mhigh_ff <= 12'd2248;
      end else if (wr) begin
         unique case (idx)
            REG_STABLE: stable_ff <= csr_pwdata[15:0];
            REG_CLOW:   clow_ff   <= csr_pwdata[11:0];
            REG_CHIGH:  chigh_ff  <= csr_pwdata[11:0];
            REG_MLOW:   mlow_ff   <= csr_pwdata[11:0];
            REG_MHIGH:  mhigh_ff  <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (idx)
         REG_STABLE: csr_prdata = {16'd0, stable_ff};
         REG_CLOW:   csr_prdata = {20'd0, clow_ff};
         REG_CHIGH:  csr_prdata = {20'd0, chigh_ff};
         REG_MLOW:   csr_prdata = {20'd0, mlow_ff};
         REG_MHIGH:  csr_prdata = {20'd0, mhigh_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign req_full = q_full;

   jcm_front u_front (
      .clock, .reset, .req_push, .req_data, .q_full, .q_push, .q_data(q_wdata),
      .stable_samples(stable_ff), .corner_low_limit(clow_ff),
      .corner_high_limit(chigh_ff), .center_low_limit(mlow_ff),
      .center_high_limit(mhigh_ff)
   );

   jcm_queue u_queue (
      .clock, .reset, .push(q_push), .wdata(q_wdata), .full(q_full),
      .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
   );

   jcm_back u_back (
      .clock, .reset, .q_empty, .q_data(q_rdata), .q_pop,
      .rsp_empty, .rsp_pop, .rsp_data
   );
endmodule

[test/joystick_calibrate_and_map_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_calibrate_and_map_top_tb
// Self-checking bench for the joystick calibration and mapping block.
// Directed commands and calibration runs, then random sequences that walk the
// six calibration phases under several threshold settings and idle patterns.
// A built-in predictor computes each result; the monitor compares in order.
// ----------------------------------------------------------------------------
module joystick_calibrate_and_map_top_tb;
   import jcm_pkg::*;

   localparam int CycleLimit = 3000000;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   req_type     req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   joystick_calibrate_and_map_top dut (.*);

   // Predictor state
   logic [15:0] stable_cfg;
   logic [11:0] corner_lo_cfg, corner_hi_cfg, center_lo_cfg, center_hi_cfg;
   logic [11:0] cal_low [4];
   logic [11:0] cal_high [4];
   logic [11:0] cal_mid [4];
   logic [2:0]  cal_phase_q;
   logic [15:0] steady_q;

   req_type pending_requests[$];
   rsp_type expected_results[$];
   int      idle_pct, stall_pct, error_count, cycle_count;
   bit      hold_sender;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic void restore_calibration();
      for (int i = 0; i < 4; i++) begin
         cal_low[i] = 12'd0;
         cal_high[i] = 12'hfff;
         cal_mid[i] = 12'd2048;
      end
   endfunction

   function automatic logic [7:0] map_position(input logic [11:0] v, input int i);
      int lo, hi, c;
      lo = cal_low[i]; hi = cal_high[i]; c = cal_mid[i];
      if (v <= c) begin
         if (v <= lo) return 8'd0;
         return 8'(128 - ((c - v) * 128) / (c - lo));
      end
      if (v >= hi) return 8'd255;
      return 8'(128 + ((v - c) * 127) / (hi - c));
   endfunction

   // Advance the calibration sequencer by one sample
   function automatic void calibrate_sample(input logic [11:0] s [4]);
      int base, kind;
      logic [11:0] a, b;
      bit ok;
      if (cal_phase_q < 3'd1 || cal_phase_q > 3'd6) return;
      base = (cal_phase_q <= 3'd3) ? 0 : 2;
      kind = (cal_phase_q - 1) % 3;
      a = s[base]; b = s[base + 1];
      if (kind == 0) ok = a < corner_lo_cfg && b < corner_lo_cfg;
      else if (kind == 1) ok = a > corner_hi_cfg && b > corner_hi_cfg;
      else ok = a > center_lo_cfg && a < center_hi_cfg
                && b > center_lo_cfg && b < center_hi_cfg;
      if (!ok) begin
         steady_q = 16'd0;
         return;
      end
      steady_q = steady_q + 16'd1;
      if (steady_q >= stable_cfg) begin
         if (kind == 0) begin cal_low[base] = a; cal_low[base + 1] = b; end
         else if (kind == 1) begin cal_high[base] = a; cal_high[base + 1] = b; end
         else begin cal_mid[base] = a; cal_mid[base + 1] = b; end
         cal_phase_q = cal_phase_q + 3'd1;
         steady_q = 16'd0;
      end
   endfunction

   function automatic rsp_type predict_result(input req_type r);
      rsp_type res;
      logic [11:0] s [4];
      s[0] = r.left_x_raw; s[1] = r.left_y_raw;
      s[2] = r.right_x_raw; s[3] = r.right_y_raw;
      res = '0;
      case (r.cmd)
         CMD_SAMPLE: begin
            calibrate_sample(s);
            res.left_x_out = map_position(s[0], 0);
            res.left_y_out = map_position(s[1], 1);
            res.right_x_out = map_position(s[2], 2);
            res.right_y_out = map_position(s[3], 3);
         end
         CMD_START: begin cal_phase_q = PH_LMIN; steady_q = '0; end
         CMD_ABORT: begin cal_phase_q = PH_IDLE; steady_q = '0; end
         default: begin
            restore_calibration();
            cal_phase_q = PH_IDLE;
            steady_q = '0;
         end
      endcase
      res.phase = cal_phase_q;
      res.calibrating = cal_phase_q >= PH_LMIN && cal_phase_q <= PH_RCTR;
      res.complete = cal_phase_q == PH_DONE;
      return res;
   endfunction

   // Driver: push queued requests, idling at random
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         req_data <= '0;
      end else begin
         automatic bit taken = req_push && !req_full;
         if (taken) expected_results.push_back(predict_result(req_data));
         if ((!req_push || taken)) begin
            if (pending_requests.size() > 0 && !hold_sender
                && $urandom_range(99) >= idle_pct) begin
               req_push <= 1'b1;
               req_data <= pending_requests.pop_front();
            end else begin
               req_push <= 1'b0;
               req_data <= '0;
            end
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               automatic rsp_type w = expected_results.pop_front();
               if (rsp_data.left_x_out != w.left_x_out)
                  report_mismatch("left_x_out", rsp_data.left_x_out, w.left_x_out);
               if (rsp_data.left_y_out != w.left_y_out)
                  report_mismatch("left_y_out", rsp_data.left_y_out, w.left_y_out);
               if (rsp_data.right_x_out != w.right_x_out)
                  report_mismatch("right_x_out", rsp_data.right_x_out, w.right_x_out);
               if (rsp_data.right_y_out != w.right_y_out)
                  report_mismatch("right_y_out", rsp_data.right_y_out, w.right_y_out);
               if (rsp_data.phase != w.phase)
                  report_mismatch("phase", rsp_data.phase, w.phase);
               if (rsp_data.calibrating != w.calibrating)
                  report_mismatch("calibrating", rsp_data.calibrating, w.calibrating);
               if (rsp_data.complete != w.complete)
                  report_mismatch("complete", rsp_data.complete, w.complete);
            end
         end
         rsp_pop <= $urandom_range(99) >= stall_pct;
      end
   end

   // Timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[joystick_calibrate_and_map_top] ERROR");
         $finish;
      end
   end

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= 5'(index * 4); csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (index)
         REG_STABLE: stable_cfg = value[15:0];
         REG_CLOW:   corner_lo_cfg = value[11:0];
         REG_CHIGH:  corner_hi_cfg = value[11:0];
         REG_MLOW:   center_lo_cfg = value[11:0];
         default:    center_hi_cfg = value[11:0];
      endcase
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || req_push || expected_results.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic void queue_request(input logic [1:0] c, input int lx, input int ly,
                                         input int rx, input int ry);
      req_type r;
      r.cmd = c;
      r.left_x_raw = 12'(lx); r.left_y_raw = 12'(ly);
      r.right_x_raw = 12'(rx); r.right_y_raw = 12'(ry);
      pending_requests.push_back(r);
   endfunction

   function automatic int pick_axis(input int kind);
      case (kind)
         0: return $urandom_range(corner_lo_cfg > 0 ? corner_lo_cfg - 1 : 0);
         1: return $urandom_range(4095, corner_hi_cfg < 4095 ? corner_hi_cfg + 1 : 4095);
         default: return (center_hi_cfg > center_lo_cfg + 1)
                         ? $urandom_range(center_hi_cfg - 1, center_lo_cfg + 1)
                         : $urandom_range(4095);
      endcase
   endfunction

   // Queue one calibration walk: mostly qualifying samples, some noise
   function automatic void queue_calibration(input int per_phase);
      queue_request(CMD_START, $urandom, $urandom, $urandom, $urandom);
      for (int ph = 1; ph <= 6; ph++) begin
         for (int k = 0; k < per_phase; k++) begin
            automatic int kind = (ph - 1) % 3;
            if ($urandom_range(99) < 8)
               queue_request(CMD_SAMPLE, $urandom, $urandom, $urandom, $urandom);
            else if (ph <= 3)
               queue_request(CMD_SAMPLE, pick_axis(kind), pick_axis(kind),
                             $urandom, $urandom);
            else
               queue_request(CMD_SAMPLE, $urandom, $urandom,
                             pick_axis(kind), pick_axis(kind));
         end
      end
   endfunction

   initial begin
      int stable_sel [5];
      stable_sel = '{1, 2, 3, 0, 4};
      reset = 1'b1;
      req_push = 1'b0; req_data = '0; rsp_pop = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      idle_pct = 0; stall_pct = 0; error_count = 0; cycle_count = 0;
      hold_sender = 1'b0;
      stable_cfg = 16'd50; corner_lo_cfg = 12'd500; corner_hi_cfg = 12'd3595;
      center_lo_cfg = 12'd1848; center_hi_cfg = 12'd2248;
      restore_calibration();
      cal_phase_q = PH_IDLE; steady_q = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes and every command on reset data
      queue_request(CMD_SAMPLE, 0, 4095, 2048, 2049);
      queue_request(CMD_SAMPLE, 4095, 0, 1, 4094);
      queue_request(CMD_ABORT, 4095, 4095, 4095, 4095);
      queue_request(CMD_START, 0, 0, 0, 0);
      queue_request(CMD_SAMPLE, 10, 20, 4095, 4095);
      queue_request(CMD_RESET, 1, 2, 3, 4);
      drain();
      // Directed: one-sample phases, a full walk and an aborted walk
      write_register(REG_STABLE, 32'd1);
      queue_request(CMD_START, 0, 0, 0, 0);
      queue_request(CMD_SAMPLE, 100, 200, 0, 0);
      queue_request(CMD_SAMPLE, 4000, 3900, 0, 0);
      queue_request(CMD_SAMPLE, 2000, 2100, 0, 0);
      queue_request(CMD_SAMPLE, 0, 0, 0, 0);
      queue_request(CMD_SAMPLE, 0, 0, 4095, 4095);
      queue_request(CMD_SAMPLE, 0, 0, 1900, 2247);
      queue_request(CMD_SAMPLE, 100, 4000, 2000, 4095);
      queue_request(CMD_SAMPLE, 101, 3999, 1, 4094);
      queue_request(CMD_SAMPLE, 2000, 2100, 2048, 0);
      queue_request(CMD_START, 0, 0, 0, 0);
      queue_request(CMD_SAMPLE, 0, 0, 0, 0);
      queue_request(CMD_SAMPLE, 4095, 4095, 0, 0);
      queue_request(CMD_SAMPLE, 4095, 4095, 0, 0);
      queue_request(CMD_SAMPLE, 2100, 1, 0, 0);
      queue_request(CMD_ABORT, 0, 0, 0, 0);
      drain();

      // Random phases with changing thresholds and idle patterns
      for (int p = 0; p < 5; p++) begin
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 46; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 32; stall_pct = 32; end
         endcase
         write_register(REG_STABLE, stable_sel[p]);
         if (p == 3) begin
            write_register(REG_CLOW, 32'd4095);
            write_register(REG_CHIGH, 32'd0);
            write_register(REG_MLOW, 32'd0);
            write_register(REG_MHIGH, 32'd4095);
         end else if (p == 4) begin
            write_register(REG_CLOW, 32'd0);
            write_register(REG_CHIGH, 32'd4095);
            write_register(REG_MLOW, 32'd2000);
            write_register(REG_MHIGH, 32'd2001);
         end else begin
            write_register(REG_CLOW, $urandom_range(1500, 1));
            write_register(REG_CHIGH, $urandom_range(4094, 2600));
            write_register(REG_MLOW, $urandom_range(1900, 1500));
            write_register(REG_MHIGH, $urandom_range(2600, 2100));
         end
         for (int s = 0; s < 270; ) begin
            automatic int pick = $urandom_range(99);
            if (pick < 55) begin
               queue_calibration(stable_sel[p] + 1);
               s += 6 * (stable_sel[p] + 1) + 1;
            end else if (pick < 65) begin
               queue_request(2'($urandom_range(3, 1)), $urandom, $urandom,
                             $urandom, $urandom);
               s++;
            end else begin
               queue_request(CMD_SAMPLE, $urandom, $urandom, $urandom, $urandom);
               s++;
            end
         end
         // Midway through, hold off until everything has drained, then resume
         if (p == 1) begin
            while (pending_requests.size() > 135) @(posedge clock);
            hold_sender = 1'b1;
            while (expected_results.size() > 0 || req_push) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain();
      end

      if (error_count == 0) begin
         $display("[joystick_calibrate_and_map_top] OK");
      end else begin
         $display("[joystick_calibrate_and_map_top] ERROR");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/jcm_pkg.sv
rtl/core/jcm_front.sv
rtl/core/jcm_queue.sv
rtl/core/jcm_back.sv
rtl/core/joystick_calibrate_and_map_top.sv
test/joystick_calibrate_and_map_top_tb.sv
